>>> rtl/core/ranked_array_table_defines.svh
// ----------------------------------------------------------------------------
// ranked_array_table_defines
// Assertion macros used by the ranked array table RTL.
// ----------------------------------------------------------------------------
`ifndef RANKED_ARRAY_TABLE_DEFINES_SVH
`define RANKED_ARRAY_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Check an implication on every clock edge outside reset.
`define RAT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define RAT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RAT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/core/rat_pkg.sv
// ----------------------------------------------------------------------------
// rat_pkg
// Types and constants of the ranked array table.
// ----------------------------------------------------------------------------
package rat_pkg;

  localparam int unsigned DepthDef = 64;
  localparam int unsigned WidthDef = 32;

  typedef enum logic [2:0] {
    KIND_FIND   = 3'd0,
    KIND_SEARCH = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_READ   = 3'd4,
    KIND_WRITE  = 3'd5,
    KIND_UNIQ   = 3'd6
  } kind_e;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StBad  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_USE,
    S_WR,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_LAST,
    PH_SCAN
  } phase_e;

endpackage

>>> rtl/core/ranked_array_table.sv
// ----------------------------------------------------------------------------
// ranked_array_table
// Ranked table of signed words with find, search, insert, remove, uniquify, read and write.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command transaction:
//   kind, value, first_rank, last_rank. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result transaction per command.
//   All words live in a single-port-read, single-port-write memory; a small
//   sequencer walks it, issuing each memory read and then using its data.
//   Find and search scan rank by rank (search first checks the two end
//   words); insert and remove walk each moved word; uniquify walks every
//   stored word. The longest command is a search over the whole table with
//   no match. One command is in flight at a time: in_stall_o is high from
//   acceptance until the result is taken.
//   When the receiver stalls, the result holds steady in its output register
//   and no new command is taken.
//   Reset clears the element count; stored words need no clearing because
//   only ranks below the count are ever read.
// ----------------------------------------------------------------------------
`include "ranked_array_table_defines.svh"

module ranked_array_table
  import rat_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned WIDTH = WidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] value_i,
  input  logic [6:0]         first_rank_i,
  input  logic [6:0]         last_rank_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [5:0]         rank_o,
  output logic signed [31:0] read_value_o,
  output logic [6:0]         count_o,
  output logic [1:0]         status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned RW = (CW > 7) ? CW : 7;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  phase_e phase_q, phase_d;

  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]    ptr_q, ptr_d, wptr_q, wptr_d;
  logic [CW-1:0]    rank_q, rank_d;
  logic             found_q, found_d;
  logic [1:0]       status_q, status_d;
  logic [WIDTH-1:0] val_q, val_d, last_q, last_d;
  logic [31:0]      rdv_q, rdv_d;

  // memory port
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [WIDTH-1:0] mem_wdata, mem_rdata;

  // sequencer decisions
  logic dec_done, dec_wr, use_done, use_wr;

  // input decode
  logic [RW-1:0]       lo_in, hi_in, cnt_w;
  logic                range_ok;
  logic [WIDTH+31:0]   val_ext, rd_ext;
  logic [CW-1:0]       ptr_inc, wptr_inc;
  logic [RW-1:0]       rank_w, count_w;

  assign lo_in    = RW'(first_rank_i);
  assign hi_in    = RW'(last_rank_i);
  assign cnt_w    = RW'(count_q);
  assign range_ok = (lo_in <= hi_in) && (hi_in <= cnt_w);
  // stored words are the sign-extended command value cut to WIDTH bits
  assign val_ext  = {{WIDTH{value_i[31]}}, value_i};
  assign rd_ext   = {{32{mem_rdata[WIDTH-1]}}, mem_rdata};
  assign ptr_inc  = ptr_q + 1'b1;
  assign wptr_inc = wptr_q + 1'b1;

  rat_mem #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(ptr_q[AW-1:0]),
    .rdata_o(mem_rdata)
  );

  assign mem_re = (state_q == S_RD);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (dec_done) begin
            state_d = S_OUT;
          end else if (dec_wr) begin
            state_d = S_WR;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD:  state_d = S_USE;
      S_USE: begin
        if (use_done) begin
          state_d = S_OUT;
        end else if (use_wr) begin
          state_d = S_WR;
        end else begin
          state_d = S_RD;
        end
      end
      S_WR:  state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    kind_d    = kind_q;
    phase_d   = phase_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    ptr_d     = ptr_q;
    wptr_d    = wptr_q;
    rank_d    = rank_q;
    found_d   = found_q;
    status_d  = status_q;
    val_d     = val_q;
    last_d    = last_q;
    rdv_d     = rdv_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_inc[AW-1:0];
    mem_wdata = mem_rdata;
    dec_done  = 1'b0;
    dec_wr    = 1'b0;
    use_done  = 1'b0;
    use_wr    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d   = kind_e'(kind_i);
          val_d    = val_ext[WIDTH-1:0];
          lo_d     = CW'(lo_in);
          hi_d     = CW'(hi_in);
          found_d  = 1'b0;
          rank_d   = '0;
          rdv_d    = '0;
          status_d = StOk;
          case (kind_e'(kind_i))
            KIND_FIND, KIND_SEARCH: begin
              if (!range_ok) begin
                status_d = StBad;
                dec_done = 1'b1;
              end else if (lo_in == hi_in) begin
                dec_done = 1'b1;
              end else begin
                ptr_d   = CW'(lo_in);
                phase_d = (kind_e'(kind_i) == KIND_SEARCH) ? PH_FIRST : PH_SCAN;
              end
            end
            KIND_INSERT: begin
              if (lo_in > cnt_w) begin
                status_d = StBad;
                dec_done = 1'b1;
              end else if (count_q == CW'(DEPTH)) begin
                status_d = StFull;
                dec_done = 1'b1;
              end else if (lo_in == cnt_w) begin
                dec_wr = 1'b1;
              end else begin
                ptr_d = count_q - 1'b1;
              end
            end
            KIND_REMOVE: begin
              if (!range_ok) begin
                status_d = StBad;
                dec_done = 1'b1;
              end else if (hi_in == cnt_w) begin
                count_d  = count_q - (CW'(hi_in) - CW'(lo_in));
                dec_done = 1'b1;
              end else begin
                ptr_d  = CW'(hi_in);
                wptr_d = CW'(lo_in);
              end
            end
            KIND_READ: begin
              if (lo_in >= cnt_w) begin
                status_d = StBad;
                dec_done = 1'b1;
              end else begin
                ptr_d = CW'(lo_in);
              end
            end
            KIND_WRITE: begin
              if (lo_in >= cnt_w) begin
                status_d = StBad;
                dec_done = 1'b1;
              end else begin
                dec_wr = 1'b1;
              end
            end
            KIND_UNIQ: begin
              if (count_q == '0) begin
                dec_done = 1'b1;
              end else begin
                ptr_d   = '0;
                phase_d = PH_FIRST;
              end
            end
            default: begin
              status_d = StBad;
              dec_done = 1'b1;
            end
          endcase
        end
      end
      S_USE: begin
        case (kind_q)
          KIND_FIND, KIND_SEARCH: begin
            case (phase_q)
              PH_FIRST: begin
                // reject early when the value sits below the first word
                if ($signed(val_q) < $signed(mem_rdata)) begin
                  use_done = 1'b1;
                end else begin
                  ptr_d   = hi_q - 1'b1;
                  phase_d = PH_LAST;
                end
              end
              PH_LAST: begin
                if ($signed(mem_rdata) < $signed(val_q)) begin
                  use_done = 1'b1;
                end else begin
                  ptr_d   = lo_q;
                  phase_d = PH_SCAN;
                end
              end
              default: begin
                if (mem_rdata == val_q) begin
                  found_d  = 1'b1;
                  rank_d   = ptr_q;
                  use_done = 1'b1;
                end else begin
                  ptr_d    = ptr_inc;
                  use_done = (ptr_inc == hi_q);
                end
              end
            endcase
          end
          KIND_INSERT: begin
            // move the word up one rank, walking down from the top
            mem_we = 1'b1;
            if (ptr_q == lo_q) begin
              use_wr = 1'b1;
            end else begin
              ptr_d = ptr_q - 1'b1;
            end
          end
          KIND_REMOVE: begin
            mem_we    = 1'b1;
            mem_waddr = wptr_q[AW-1:0];
            ptr_d     = ptr_inc;
            wptr_d    = wptr_inc;
            if (ptr_inc == count_q) begin
              count_d  = count_q - (hi_q - lo_q);
              use_done = 1'b1;
            end
          end
          KIND_READ: begin
            rdv_d    = rd_ext[31:0];
            use_done = 1'b1;
          end
          KIND_UNIQ: begin
            if (phase_q == PH_FIRST) begin
              last_d  = mem_rdata;
              wptr_d  = '0;
              phase_d = PH_SCAN;
              if (count_q == CW'(1)) begin
                use_done = 1'b1;
              end else begin
                ptr_d = ptr_inc;
              end
            end else begin
              // keep the first word of each run, packing it down
              if (mem_rdata != last_q) begin
                mem_we    = 1'b1;
                mem_waddr = wptr_inc[AW-1:0];
                wptr_d    = wptr_inc;
                last_d    = mem_rdata;
              end
              ptr_d = ptr_inc;
              if (ptr_inc == count_q) begin
                count_d  = ((mem_rdata != last_q) ? wptr_inc : wptr_q) + 1'b1;
                use_done = 1'b1;
              end
            end
          end
          default: use_done = 1'b1;
        endcase
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q[AW-1:0];
        mem_wdata = val_q;
        if (kind_q == KIND_INSERT) begin
          count_d = count_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= KIND_FIND;
      phase_q  <= PH_SCAN;
      count_q  <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      ptr_q    <= '0;
      wptr_q   <= '0;
      found_q  <= 1'b0;
      status_q <= StOk;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      phase_q  <= phase_d;
      count_q  <= count_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      ptr_q    <= ptr_d;
      wptr_q   <= wptr_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    last_q <= last_d;
    rdv_q  <= rdv_d;
    rank_q <= rank_d;
  end

  assign rank_w  = RW'(rank_q);
  assign count_w = RW'(count_q);

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign found_o      = found_q;
  assign rank_o       = rank_w[5:0];
  assign read_value_o = rdv_q;
  assign count_o      = count_w[6:0];
  assign status_o     = status_q;

  `RAT_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CW'(DEPTH), "count above depth")
  `RAT_ASSERT(a_valid_busy, clk_i, rst_ni, out_valid_o |-> in_stall_o, "result while idle")
  `RAT_ASSERT(a_full_flag, clk_i, rst_ni, (out_valid_o && status_o == StFull) |-> (count_q == CW'(DEPTH)), "full flag, room left")
  `RAT_ASSERT(a_found_ok, clk_i, rst_ni, (out_valid_o && found_o) |-> (status_o == StOk), "found with bad status")

endmodule

>>> rtl/core/rat_mem.sv
// ----------------------------------------------------------------------------
// rat_mem
// Element store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rat_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
